// File: hw/rtl/voxel_visible_face_cull_unit_defines.svh
// Assertion macros shared by the voxel face cull RTL.
// No dependencies; modules that assert include this file by name.
`ifndef VOXEL_VISIBLE_FACE_CULL_UNIT_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_CULL_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define VVFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define VVFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/vvfc_pkg.sv
// Shared types, codes and constants of the voxel face cull unit.
// No dependencies; used by all modules.
package vvfc_pkg;

	localparam int EDGE_LENGTH_DEF = 16;
	localparam int TOTAL_W         = 19;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [3:0] VPF_RESET = 4'd6;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_BEGIN = 2'd1;
	localparam logic [1:0] KIND_CULL  = 2'd2;

	// row read steps of a lookup
	localparam logic [2:0] STEP_CTR = 3'd0; // own row (x,y): own bit, +z, -z
	localparam logic [2:0] STEP_XP  = 3'd1;
	localparam logic [2:0] STEP_XM  = 3'd2;
	localparam logic [2:0] STEP_YP  = 3'd3;
	localparam logic [2:0] STEP_YM  = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] pos_x;
		logic [4:0] pos_y;
		logic [4:0] pos_z;
		logic       occupied;
	} vvfc_item_t;

	typedef struct packed {
		logic [5:0]         face_mask;
		logic               voxel_present;
		logic [TOTAL_W-1:0] vertex_total;
		logic               out_of_range;
	} vvfc_result_t;

	// controller -> datapath
	typedef struct packed {
		logic       clr_we;
		logic       load;
		logic       rd_en;
		logic [2:0] rd_step;
		logic       commit;
	} vvfc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic needs_mem;
		logic is_write;
		logic out_free;
	} vvfc_sts_t;

endpackage

// File: hw/rtl/vvfc_chan_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type set per instance; used with the types of vvfc_pkg.
interface vvfc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/vvfc_ctrl.sv
// Sequencer of the voxel face cull unit: clear sweep, row reads, commit.
// Depends on vvfc_pkg and the assertion macro header.
`include "voxel_visible_face_cull_unit_defines.svh"

module vvfc_ctrl
	import vvfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  vvfc_sts_t sts,
	output vvfc_cmd_t dp_cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_LAST  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] step_q, step_d;
	logic       last_step;

	// a write needs only its own row, a cull all five
	assign last_step = (sts.is_write && step_q == STEP_CTR) || step_q == STEP_YM;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cmd_ready = 1'b0;
		dp_cmd    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				dp_cmd.clr_we = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd_ready   = 1'b1;
				dp_cmd.load = cmd_valid;
				if (cmd_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				step_d  = STEP_CTR;
				state_d = sts.needs_mem ? ST_READ : ST_FIN;
			end
			ST_READ: begin
				dp_cmd.rd_en   = 1'b1;
				dp_cmd.rd_step = step_q;
				if (last_step) begin
					state_d = ST_LAST;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			ST_LAST: begin
				// last row lands in the datapath
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					dp_cmd.commit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= STEP_CTR;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	`VVFC_ASSERT_NEXT(a_accept_to_check, state_q == ST_IDLE && cmd_valid, state_q == ST_CHECK, "accepted beat did not start a lookup")
	`VVFC_ASSERT_NOW(a_step_bound, state_q == ST_READ, step_q <= STEP_YM, "row step past last neighbor")
	`VVFC_ASSERT_NOW(a_write_one_row, state_q == ST_READ && sts.is_write, step_q == STEP_CTR, "write item read more than its own row")

endmodule

// File: hw/rtl/vvfc_datapath.sv
// Datapath of the voxel face cull unit: occupancy row memory, neighbor
// bits, vertex total, config register and result register. Uses vvfc_pkg.
`include "voxel_visible_face_cull_unit_defines.svh"

module vvfc_datapath
	import vvfc_pkg::*;
#(
	parameter int EDGE_LENGTH = EDGE_LENGTH_DEF
)(
	input  logic         clk,
	input  logic         arst_n,
	input  vvfc_cmd_t    dp_cmd,
	output vvfc_sts_t    sts,
	input  vvfc_item_t   cmd_data,
	input  logic         cfg_valid,
	input  logic [3:0]   cfg_data,
	output logic         out_valid,
	input  logic         out_ready,
	output vvfc_result_t out_data
);

	localparam int ROWS = EDGE_LENGTH * EDGE_LENGTH;
	localparam int AW   = $clog2(ROWS);
	localparam int ZW   = $clog2(EDGE_LENGTH);
	localparam logic [5:0]    EDGE6    = 6'(EDGE_LENGTH);
	localparam logic [AW-1:0] EDGE_A   = AW'(EDGE_LENGTH);
	localparam logic [AW-1:0] ROW_LAST = AW'(ROWS - 1);

	vvfc_item_t           item_q;
	logic [3:0]           vpf_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [EDGE_LENGTH-1:0] occ_mem_q [ROWS];
	logic [EDGE_LENGTH-1:0] rd_q;
	logic                 rd_vld_s1;
	logic [2:0]           rd_step_s1;
	logic [EDGE_LENGTH-1:0] ctr_row_q;
	logic                 present_q;
	logic [5:0]           face_q;
	logic                 out_valid_q;
	vvfc_result_t         res_q;

	logic                 in_rng, xp_ok, xm_ok, yp_ok, ym_ok, zp_ok, zm_ok;
	logic [4:0]           xp, xm, yp, ym;
	logic [ZW-1:0]        zi, zpi, zmi;
	logic [AW-1:0]        ctr_addr, rd_addr, wr_addr;
	logic [EDGE_LENGTH-1:0] new_row, wr_row;
	logic                 mem_we;
	logic [2:0]           face_cnt;
	logic [6:0]           add_v;
	logic [TOTAL_W:0]     sum;
	logic [TOTAL_W-1:0]   total_d;
	vvfc_result_t         res_d;

	function automatic logic [AW-1:0] row_of(input logic [4:0] xx, input logic [4:0] yy);
		row_of = AW'(AW'(xx) * EDGE_A + AW'(yy));
	endfunction

	// coordinate checks and neighbor coordinates
	assign in_rng = ({1'b0, item_q.pos_x} < EDGE6) && ({1'b0, item_q.pos_y} < EDGE6)
		&& ({1'b0, item_q.pos_z} < EDGE6);
	assign xp_ok = ({1'b0, item_q.pos_x} + 6'd1) < EDGE6;
	assign yp_ok = ({1'b0, item_q.pos_y} + 6'd1) < EDGE6;
	assign zp_ok = ({1'b0, item_q.pos_z} + 6'd1) < EDGE6;
	assign xm_ok = item_q.pos_x != 5'd0;
	assign ym_ok = item_q.pos_y != 5'd0;
	assign zm_ok = item_q.pos_z != 5'd0;
	assign xp    = item_q.pos_x + 5'd1;
	assign xm    = item_q.pos_x - 5'd1;
	assign yp    = item_q.pos_y + 5'd1;
	assign ym    = item_q.pos_y - 5'd1;
	assign zi    = item_q.pos_z[ZW-1:0];
	assign zpi   = zi + ZW'(1);
	assign zmi   = zi - ZW'(1);

	assign sts.needs_mem = in_rng && (item_q.kind == KIND_WRITE || item_q.kind == KIND_CULL);
	assign sts.is_write  = item_q.kind == KIND_WRITE;
	assign sts.clr_last  = clr_cnt_q == ROW_LAST;
	assign sts.out_free  = !out_valid_q || out_ready;

	// row address per read step; a neighbor off the chunk rereads the own row
	assign ctr_addr = row_of(item_q.pos_x, item_q.pos_y);
	always_comb begin
		unique case (dp_cmd.rd_step)
			STEP_XP: rd_addr = xp_ok ? row_of(xp, item_q.pos_y) : ctr_addr;
			STEP_XM: rd_addr = xm_ok ? row_of(xm, item_q.pos_y) : ctr_addr;
			STEP_YP: rd_addr = yp_ok ? row_of(item_q.pos_x, yp) : ctr_addr;
			STEP_YM: rd_addr = ym_ok ? row_of(item_q.pos_x, ym) : ctr_addr;
			default: rd_addr = ctr_addr;
		endcase
	end

	// own row with the written bit replaced
	always_comb begin
		new_row     = ctr_row_q;
		new_row[zi] = item_q.occupied;
	end

	// write port: clear sweep or voxel write
	assign mem_we  = dp_cmd.clr_we
		|| (dp_cmd.commit && item_q.kind == KIND_WRITE && in_rng);
	assign wr_addr = dp_cmd.clr_we ? clr_cnt_q : ctr_addr;
	assign wr_row  = dp_cmd.clr_we ? '0 : new_row;

	// occupancy memory, one row of z bits per (x,y)
	always_ff @(posedge clk) begin
		if (mem_we) occ_mem_q[wr_addr] <= wr_row;
		if (dp_cmd.rd_en) rd_q <= occ_mem_q[rd_addr];
	end

	// step tag follows the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_step_s1 <= STEP_CTR;
		end else begin
			rd_vld_s1  <= dp_cmd.rd_en;
			rd_step_s1 <= dp_cmd.rd_step;
		end
	end

	// item capture and neighbor bits (1 = face open)
	always_ff @(posedge clk) begin
		if (dp_cmd.load) item_q <= cmd_data;
		if (rd_vld_s1) begin
			unique case (rd_step_s1)
				STEP_CTR: begin
					ctr_row_q <= rd_q;
					present_q <= rd_q[zi];
					face_q[4] <= !(zp_ok && rd_q[zpi]);
					face_q[5] <= !(zm_ok && rd_q[zmi]);
				end
				STEP_XP: face_q[0] <= !(xp_ok && rd_q[zi]);
				STEP_XM: face_q[1] <= !(xm_ok && rd_q[zi]);
				STEP_YP: face_q[2] <= !(yp_ok && rd_q[zi]);
				STEP_YM: face_q[3] <= !(ym_ok && rd_q[zi]);
				default: ;
			endcase
		end
	end

	// vertex total update and result
	assign face_cnt = 3'($countones(face_q));
	assign add_v    = 7'(face_cnt) * 7'(vpf_q);
	assign sum      = {1'b0, total_q} + (TOTAL_W + 1)'(add_v);

	always_comb begin
		total_d = total_q;
		res_d   = '0;
		unique case (item_q.kind)
			KIND_BEGIN: total_d = '0;
			KIND_WRITE: begin
				if (!in_rng) begin
					res_d.out_of_range = 1'b1;
				end else begin
					res_d.voxel_present = item_q.occupied;
				end
			end
			KIND_CULL: begin
				if (!in_rng) begin
					res_d.out_of_range = 1'b1;
				end else if (present_q) begin
					res_d.voxel_present = 1'b1;
					res_d.face_mask     = face_q;
					total_d = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
				end
			end
			default: ;
		endcase
		res_d.vertex_total = total_d;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) res_q <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpf_q       <= VPF_RESET;
			total_q     <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) vpf_q <= cfg_data;
			if (dp_cmd.commit) total_q <= total_d;
			if (dp_cmd.clr_we) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (dp_cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	`VVFC_ASSERT_NOW(a_commit_room, dp_cmd.commit, !out_valid_q || out_ready, "result overwritten before taken")

endmodule

// File: hw/rtl/voxel_visible_face_cull_unit.sv
// Top level of the voxel visible face cull unit.
// Depends on vvfc_pkg, vvfc_chan_if, vvfc_ctrl and vvfc_datapath.
//
// Channels: cmd (sink) takes one item per beat: kind, pos_x/y/z, occupied.
// result (source) gives one beat per item: face_mask, voxel_present,
// vertex_total, out_of_range. cfg (sink) writes the per-face vertex count;
// it is always ready and a beat takes effect at once.
// Sequence: an in-range cull reads its own z-row and four neighbor rows,
// one per cycle, through the single read port of the occupancy memory;
// an in-range write reads its own row and writes it back. A begin, an
// unused kind or an out-of-range item reads no row. Each item ends in a
// commit to the result register; the result is valid from the cycle in
// which the next item can be accepted.
// Reset: the occupancy memory is swept to zero, one row per cycle, over
// all EDGE_LENGTH^2 rows (256 at the default edge) with cmd.ready low;
// the total clears and the per-face vertex count returns to 6.
// A stalled result stays in the output register; the next item is still
// accepted and held at its commit until the register is free.
module voxel_visible_face_cull_unit
	import vvfc_pkg::*;
#(
	parameter int EDGE_LENGTH = EDGE_LENGTH_DEF
)(
	input logic         clk,
	input logic         arst_n,
	vvfc_chan_if.sink   cmd,
	vvfc_chan_if.source result,
	vvfc_chan_if.sink   cfg
);

	vvfc_cmd_t    dp_cmd;
	vvfc_sts_t    sts;
	vvfc_item_t   cmd_data;
	vvfc_result_t res_data;
	logic         cmd_ready;
	logic         res_valid;
	logic [3:0]   cfg_data;

	assign cmd_data = cmd.data;
	assign cfg_data = cfg.data;
	assign cmd.ready = cmd_ready;
	assign cfg.ready = 1'b1;
	assign result.valid = res_valid;
	assign result.data  = res_data;

	vvfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.dp_cmd    (dp_cmd)
	);

	vvfc_datapath #(
		.EDGE_LENGTH (EDGE_LENGTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.sts       (sts),
		.cmd_data  (cmd_data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg_data),
		.out_valid (res_valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

endmodule
